[rtl/core/tablet_report_to_input_events_top_assert.svh]
// assertion macros for the tablet event translator
`ifndef TABLET_REPORT_TO_INPUT_EVENTS_TOP_ASSERT_SVH
`define TABLET_REPORT_TO_INPUT_EVENTS_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TABEV_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tabev assertion failed");

// next-cycle implication, checked outside reset
`define TABEV_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tabev assertion failed");

`endif

[rtl/core/tabev_pkg.sv]
package tabev_pkg;

    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 48;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int DECODE_BYTES = 12;
    localparam int IDX_W        = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_REPORT_ID  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PEN_SERIAL = 1'b1;

    localparam logic [7:0]  REPORT_ID_RESET  = 8'd8;
    localparam logic [31:0] PEN_SERIAL_RESET = 32'd1098942556;

    localparam logic [7:0] PEN_KIND_MASK = 8'h70;
    localparam logic [7:0] BUTTONS_ID    = 8'he0;
    localparam logic [7:0] DIAL_ID       = 8'hf0;
    localparam logic [7:0] DIAL_SPLIT    = 8'd6;
    localparam logic [7:0] DIAL_HIGH_REF = 8'd19;
    localparam logic [7:0] DIAL_LOW_REF  = 8'd7;

    // 71/12 as a multiply by round-up reciprocal, exact for the dial range
    localparam logic [21:0] DIAL_SCALE_MUL   = 22'd3102038;
    localparam int          DIAL_SCALE_SHIFT = 19;
    localparam logic [32:0] MISC_ACTIVE      = 33'd15;

    localparam logic DEV_PEN = 1'b0;
    localparam logic DEV_PAD = 1'b1;

    localparam logic [1:0] TYPE_SYN = 2'd0;
    localparam logic [1:0] TYPE_KEY = 2'd1;
    localparam logic [1:0] TYPE_ABS = 2'd2;
    localparam logic [1:0] TYPE_MSC = 2'd3;

    localparam logic [4:0] CODE_X          = 5'd0;
    localparam logic [4:0] CODE_Y          = 5'd1;
    localparam logic [4:0] CODE_PRESSURE   = 5'd2;
    localparam logic [4:0] CODE_TILT_X     = 5'd3;
    localparam logic [4:0] CODE_TILT_Y     = 5'd4;
    localparam logic [4:0] CODE_PEN_TOOL   = 5'd5;
    localparam logic [4:0] CODE_TOUCH      = 5'd6;
    localparam logic [4:0] CODE_STYLUS     = 5'd7;
    localparam logic [4:0] CODE_STYLUS2    = 5'd8;
    localparam logic [4:0] CODE_SERIAL     = 5'd9;
    localparam logic [4:0] CODE_SYN_REPORT = 5'd10;
    localparam logic [4:0] CODE_MISC       = 5'd11;
    localparam logic [4:0] CODE_WHEEL      = 5'd12;
    localparam logic [4:0] CODE_PAD_BTN0   = 5'd13;

    localparam logic [IDX_W-1:0] LAST_PEN_IN  = 5'd10;
    localparam logic [IDX_W-1:0] LAST_PEN_OUT = 5'd2;
    localparam logic [IDX_W-1:0] LAST_BUTTONS = 5'd17;
    localparam logic [IDX_W-1:0] LAST_DIAL    = 5'd2;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PEN_IN,
        KIND_PEN_OUT,
        KIND_BUTTONS,
        KIND_DIAL
    } kind_t;

    typedef struct packed {
        logic in_ready;
        logic start;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic report_ok;
        logic out_free;
        logic event_final;
    } status_t;

endpackage

[rtl/core/tablet_report_to_input_events_top.sv]
// channel   dir  tdata (low bit up)                               tlast
// s_        in   report_byte[7:0]                                 last_byte
// m_        out  target_device, event_type[1:0], event_code[4:0], last_event
//                event_value[32:0], zero fill to 48 bits
// cfg_      in   index 0 report_id[7:0], index 1 pen_serial[31:0] -
// report bytes are taken while idle; the last byte leads into a decode state
// a valid report then yields 11, 3, 18 or 3 events at one event per cycle while m_tready is high
// the output register holds each event until taken; m_tready low stalls emission
// bytes are taken again once the final event sits in the output register
// reset clears the byte count and the output valid; no clearing pass
module tablet_report_to_input_events_top #(
    parameter int REPORT_BYTES = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tabev_pkg::IN_TDATA_W-1:0]     s_tdata,  // report_byte
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tabev_pkg::OUT_TDATA_W-1:0]    m_tdata,  // dev, type, code, value
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [tabev_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tabev_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tabev_pkg::*;

    cmd_t    cmd;
    status_t status;

    tabev_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    tabev_datapath #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    assign s_tready = cmd.in_ready;

endmodule

[rtl/core/tabev_datapath.sv]
module tabev_datapath #(
    parameter int REPORT_BYTES = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tabev_pkg::cmd_t                      cmd,
    output tabev_pkg::status_t                   status,
    input  logic                                 s_tvalid,
    input  logic [tabev_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tabev_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [tabev_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tabev_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tabev_pkg::*;

    localparam int CW = $clog2(REPORT_BYTES + 1);

    logic [CW-1:0]    byte_count_reg, byte_count_next;
    logic [7:0]       store_reg [DECODE_BYTES];
    logic [7:0]       report_id_reg;
    logic [31:0]      pen_serial_reg;
    kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg;
    logic             out_dev_reg;
    logic [1:0]       out_type_reg;
    logic [4:0]       out_code_reg;
    logic [32:0]      out_value_reg;

    logic             in_accept;
    logic             ev_dev;
    logic [1:0]       ev_type;
    logic [4:0]       ev_code;
    logic [32:0]      ev_value;
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      pad_keys;
    logic [7:0]       dial_raw;
    logic [7:0]       dial_mag;
    logic             dial_neg;
    logic [29:0]      dial_prod;
    logic [10:0]      dial_q;
    logic [32:0]      dial_val;

    assign in_accept = s_tvalid && cmd.in_ready;

    // report counter, saturating
    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (cmd.start)
        begin
            byte_count_next = '0;
        end
        else if (in_accept && (byte_count_reg < CW'(REPORT_BYTES)))
        begin
            byte_count_next = byte_count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (byte_count_reg < CW'(DECODE_BYTES)))
        begin
            store_reg[byte_count_reg[3:0]] <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_id_reg  <= REPORT_ID_RESET;
            pen_serial_reg <= PEN_SERIAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_REPORT_ID:  report_id_reg  <= cfg_wdata[7:0];
                REG_PEN_SERIAL: pen_serial_reg <= cfg_wdata;
                default:        report_id_reg  <= report_id_reg;
            endcase
        end
    end

    // report kind from the second byte
    always_comb
    begin
        if (store_reg[1] == BUTTONS_ID)
        begin
            kind_next = KIND_BUTTONS;
        end
        else if (store_reg[1] == DIAL_ID)
        begin
            kind_next = KIND_DIAL;
        end
        else if ((store_reg[1] & PEN_KIND_MASK) == 8'h00)
        begin
            kind_next = store_reg[1][7] ? KIND_PEN_IN : KIND_PEN_OUT;
        end
        else
        begin
            kind_next = KIND_NONE;
        end
    end

    assign status.report_ok = (byte_count_reg == CW'(REPORT_BYTES))
                              && (store_reg[0] == report_id_reg)
                              && (kind_next != KIND_NONE);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.load)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        case (kind_reg)
            KIND_PEN_IN:  last_idx = LAST_PEN_IN;
            KIND_PEN_OUT: last_idx = LAST_PEN_OUT;
            KIND_BUTTONS: last_idx = LAST_BUTTONS;
            KIND_DIAL:    last_idx = LAST_DIAL;
            default:      last_idx = '0;
        endcase
    end

    assign status.event_final = (idx_reg == last_idx);
    assign status.out_free    = !out_valid_reg || m_tready;

    // wheel position
    assign dial_raw = store_reg[5];

    always_comb
    begin
        if (dial_raw > DIAL_SPLIT)
        begin
            if (dial_raw > DIAL_HIGH_REF)
            begin
                dial_mag = dial_raw - DIAL_HIGH_REF;
                dial_neg = 1'b1;
            end
            else
            begin
                dial_mag = DIAL_HIGH_REF - dial_raw;
                dial_neg = 1'b0;
            end
        end
        else
        begin
            dial_mag = DIAL_LOW_REF - dial_raw;
            dial_neg = 1'b0;
        end
    end

    assign dial_prod = 30'(dial_mag) * 30'(DIAL_SCALE_MUL);
    assign dial_q    = dial_prod[29:DIAL_SCALE_SHIFT];

    always_comb
    begin
        if (dial_raw == 8'h00)
        begin
            dial_val = '0;
        end
        else if (dial_neg)
        begin
            dial_val = -(33'(dial_q));
        end
        else
        begin
            dial_val = 33'(dial_q);
        end
    end

    assign pad_keys = {store_reg[5], store_reg[4]};

    // event generator
    always_comb
    begin
        ev_dev   = DEV_PEN;
        ev_type  = TYPE_SYN;
        ev_code  = CODE_SYN_REPORT;
        ev_value = 33'd1;
        case (kind_reg)
            KIND_PEN_IN:
            begin
                case (idx_reg)
                    5'd0:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_X;
                        ev_value = 33'({store_reg[8], store_reg[3], store_reg[2]});
                    end
                    5'd1:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_Y;
                        ev_value = 33'({store_reg[9], store_reg[5], store_reg[4]});
                    end
                    5'd2:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_PRESSURE;
                        ev_value = 33'({store_reg[7], store_reg[6]});
                    end
                    5'd3:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_TILT_X;
                        ev_value = 33'($signed(store_reg[10]));
                    end
                    5'd4:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_TILT_Y;
                        ev_value = -(33'($signed(store_reg[11])));
                    end
                    5'd5:
                    begin
                        ev_type  = TYPE_KEY;
                        ev_code  = CODE_PEN_TOOL;
                        ev_value = 33'd1;
                    end
                    5'd6:
                    begin
                        ev_type  = TYPE_KEY;
                        ev_code  = CODE_TOUCH;
                        ev_value = 33'(store_reg[1][0]);
                    end
                    5'd7:
                    begin
                        ev_type  = TYPE_KEY;
                        ev_code  = CODE_STYLUS;
                        ev_value = 33'(store_reg[1][1]);
                    end
                    5'd8:
                    begin
                        ev_type  = TYPE_KEY;
                        ev_code  = CODE_STYLUS2;
                        ev_value = 33'(store_reg[1][2]);
                    end
                    5'd9:
                    begin
                        ev_type  = TYPE_MSC;
                        ev_code  = CODE_SERIAL;
                        ev_value = 33'(pen_serial_reg);
                    end
                    default:
                    begin
                        ev_type  = TYPE_SYN;
                    end
                endcase
            end
            KIND_PEN_OUT:
            begin
                case (idx_reg)
                    5'd0:
                    begin
                        ev_type  = TYPE_KEY;
                        ev_code  = CODE_PEN_TOOL;
                        ev_value = '0;
                    end
                    5'd1:
                    begin
                        ev_type  = TYPE_MSC;
                        ev_code  = CODE_SERIAL;
                        ev_value = 33'(pen_serial_reg);
                    end
                    default:
                    begin
                        ev_type  = TYPE_SYN;
                    end
                endcase
            end
            KIND_BUTTONS:
            begin
                ev_dev = DEV_PAD;
                if (idx_reg == '0)
                begin
                    ev_type  = TYPE_ABS;
                    ev_code  = CODE_MISC;
                    ev_value = (pad_keys != '0) ? MISC_ACTIVE : '0;
                end
                else if (idx_reg != LAST_BUTTONS)
                begin
                    ev_type  = TYPE_KEY;
                    ev_code  = idx_reg + (CODE_PAD_BTN0 - 5'd1);
                    ev_value = 33'(pad_keys[4'(idx_reg - 5'd1)]);
                end
            end
            KIND_DIAL:
            begin
                ev_dev = DEV_PAD;
                case (idx_reg)
                    5'd0:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_MISC;
                        ev_value = (dial_val != '0) ? MISC_ACTIVE : '0;
                    end
                    5'd1:
                    begin
                        ev_type  = TYPE_ABS;
                        ev_code  = CODE_WHEEL;
                        ev_value = dial_val;
                    end
                    default:
                    begin
                        ev_type  = TYPE_SYN;
                    end
                endcase
            end
            default:
            begin
                ev_dev = DEV_PEN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            kind_reg       <= KIND_NONE;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.start)
            begin
                kind_reg <= kind_next;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_dev_reg   <= ev_dev;
            out_type_reg  <= ev_type;
            out_code_reg  <= ev_code;
            out_value_reg <= ev_value;
            out_last_reg  <= status.event_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_value_reg, out_code_reg, out_type_reg, out_dev_reg});

endmodule

[rtl/core/tabev_ctrl.sv]
`include "tablet_report_to_input_events_top_assert.svh"

module tabev_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    input  tabev_pkg::status_t status,
    output tabev_pkg::cmd_t    cmd
);
    import tabev_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.start  = 1'b1;
                state_next = status.report_ok ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.event_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TABEV_ASSERT_NEXT(a_last_byte_decodes, s_tvalid && cmd.in_ready && s_tlast, state_reg == ST_DECODE)
    `TABEV_ASSERT_NEXT(a_bad_report_drops, state_reg == ST_DECODE && !status.report_ok, state_reg == ST_IDLE)
    `TABEV_ASSERT_NEXT(a_final_event_ends, cmd.load && status.event_final, state_reg == ST_IDLE)
    `TABEV_ASSERT_NOW(a_no_input_while_busy, state_reg != ST_IDLE, !cmd.in_ready && !cmd.start || state_reg == ST_DECODE)

endmodule

[verif/tb_tablet_report_to_input_events_top.sv]
`timescale 1ns / 100ps

module tb_tablet_report_to_input_events_top;

    import tabev_pkg::*;

    localparam int REPORT_LEN  = DECODE_BYTES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 30;

    typedef struct {
        logic        dev;
        logic [1:0]  etype;
        logic [4:0]  code;
        logic [32:0] value;
        logic        last;
    } tab_ev_t;

    // one directed report: named bytes, the rest filled
    typedef struct packed {
        logic [4:0] len;
        logic [7:0] id;
        logic [7:0] kind;
        logic [7:0] b5;
        logic [7:0] fill;
        logic [7:0] tx;
        logic [7:0] ty;
        logic       silent;
    } row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor copy of block state
    logic [7:0]  img [REPORT_LEN];
    int          held       = 0;
    logic [7:0]  want_id    = REPORT_ID_RESET;
    logic [31:0] serial_reg = PEN_SERIAL_RESET;

    tab_ev_t events_due [$];
    int      miss_count  = 0;
    int      bytes_sent  = 0;
    int      cycles      = 0;
    logic    in_gaps     = 1'b1;
    logic    out_gaps    = 1'b1;
    int      squeeze_len = 0;
    row_t    dir_rows [0:9];

    tablet_report_to_input_events_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (miss_count < 40)
            $display("[%0t] %s: got %0h want %0h", $realtime, what, got, want);
        miss_count++;
    endtask

    function automatic void add_ev(ref tab_ev_t evs [$], input logic dev,
                                   input logic [1:0] ty, input logic [4:0] code,
                                   input longint val);
        tab_ev_t e;
        e.dev   = dev;
        e.etype = ty;
        e.code  = code;
        e.value = val[32:0];
        e.last  = 1'b0;
        evs.push_back(e);
    endfunction

    // store one byte; on the final byte decode the report into events
    function automatic void absorb_byte(input logic [7:0] b, input logic l,
                                        ref tab_ev_t evs [$]);
        logic [7:0]  k;
        logic [15:0] mask;
        int          v;
        evs.delete();
        if (held < REPORT_LEN)
        begin
            img[held] = b;
            held++;
        end
        if (!l)
            return;
        if (held == REPORT_LEN && img[0] == want_id)
        begin
            k = img[1];
            if (k == BUTTONS_ID)
            begin
                mask = {img[5], img[4]};
                add_ev(evs, DEV_PAD, TYPE_ABS, CODE_MISC, (mask != 0) ? 15 : 0);
                for (int i = 0; i < 16; i++)
                    add_ev(evs, DEV_PAD, TYPE_KEY, CODE_PAD_BTN0 + 5'(i), mask[i]);
                add_ev(evs, DEV_PAD, TYPE_SYN, CODE_SYN_REPORT, 1);
            end
            else if (k == DIAL_ID)
            begin
                v = img[5];
                if (v != 0)
                    v = ((v > 6) ? (19 - v) : (7 - v)) * 71 / 12;
                add_ev(evs, DEV_PAD, TYPE_ABS, CODE_MISC, (v != 0) ? 15 : 0);
                add_ev(evs, DEV_PAD, TYPE_ABS, CODE_WHEEL, longint'(v));
                add_ev(evs, DEV_PAD, TYPE_SYN, CODE_SYN_REPORT, 1);
            end
            else if ((k & PEN_KIND_MASK) == 8'h00)
            begin
                if (k[7])
                begin
                    add_ev(evs, DEV_PEN, TYPE_ABS, CODE_X,
                           longint'({img[8], img[3], img[2]}));
                    add_ev(evs, DEV_PEN, TYPE_ABS, CODE_Y,
                           longint'({img[9], img[5], img[4]}));
                    add_ev(evs, DEV_PEN, TYPE_ABS, CODE_PRESSURE,
                           longint'({img[7], img[6]}));
                    add_ev(evs, DEV_PEN, TYPE_ABS, CODE_TILT_X,
                           longint'($signed(img[10])));
                    add_ev(evs, DEV_PEN, TYPE_ABS, CODE_TILT_Y,
                           -longint'($signed(img[11])));
                    add_ev(evs, DEV_PEN, TYPE_KEY, CODE_PEN_TOOL, 1);
                    add_ev(evs, DEV_PEN, TYPE_KEY, CODE_TOUCH, k[0]);
                    add_ev(evs, DEV_PEN, TYPE_KEY, CODE_STYLUS, k[1]);
                    add_ev(evs, DEV_PEN, TYPE_KEY, CODE_STYLUS2, k[2]);
                end
                else
                    add_ev(evs, DEV_PEN, TYPE_KEY, CODE_PEN_TOOL, 0);
                add_ev(evs, DEV_PEN, TYPE_MSC, CODE_SERIAL, longint'(serial_reg));
                add_ev(evs, DEV_PEN, TYPE_SYN, CODE_SYN_REPORT, 1);
            end
            if (evs.size() > 0)
                evs[evs.size() - 1].last = 1'b1;
        end
        held = 0;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic l, input logic drop);
        int      gap;
        tab_ev_t evs [$];
        gap = (in_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_byte(b, l, evs);
        if (!drop)
            foreach (evs[i])
                events_due.push_back(evs[i]);
        bytes_sent++;
    endtask

    task automatic send_report(ref logic [7:0] rb [$], input logic drop);
        foreach (rb[i])
            put_byte(rb[i], i == rb.size() - 1, drop);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (a == REG_REPORT_ID)
            want_id = d[7:0];
        else
            serial_reg = d;
    endtask

    function automatic void row_bytes(input row_t r, ref logic [7:0] rb [$]);
        rb.delete();
        for (int i = 0; i < r.len; i++)
        begin
            case (i)
                0:       rb.push_back(r.id);
                1:       rb.push_back(r.kind);
                5:       rb.push_back(r.b5);
                10:      rb.push_back(r.tx);
                11:      rb.push_back(r.ty);
                default: rb.push_back(r.fill);
            endcase
        end
    endfunction

    // mostly well-formed reports with random content, some malformed
    function automatic void random_report(ref logic [7:0] rb [$]);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = REPORT_LEN;
        if (pick >= 70 && pick < 78)
            len = $urandom_range(1, REPORT_LEN - 1);
        else if (pick >= 93)
            len = $urandom_range(REPORT_LEN + 1, REPORT_LEN + 8);
        rb.delete();
        for (int i = 0; i < len; i++)
            rb.push_back(8'($urandom_range(0, 255)));
        rb[0] = want_id;
        if (pick >= 78 && pick < 86)
            rb[0] = want_id ^ 8'($urandom_range(1, 255));
        if (len > 1)
        begin
            if (pick < 30)
                rb[1] = {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))};
            else if (pick < 50)
                rb[1] = BUTTONS_ID;
            else if (pick < 70)
                rb[1] = DIAL_ID;
            else if (pick >= 93 || pick < 78)
                rb[1] = (pick >= 93) ? 8'($urandom_range(0, 255)) : rb[1];
        end
        if (len > 5 && pick >= 50 && pick < 70 && $urandom_range(0, 1))
            rb[5] = 8'($urandom_range(0, 20));
    endfunction

    task automatic random_phase(input int n, input logic squeeze, input logic tail);
        int          start;
        int          reports;
        logic [7:0]  rb [$];
        start   = bytes_sent;
        reports = 0;
        while (bytes_sent - start < n)
        begin
            if (!tail)
            begin
                in_gaps  = ($urandom_range(0, 3) != 0);
                out_gaps = ($urandom_range(0, 3) != 0);
            end
            if (squeeze && reports == 1)
                squeeze_len = 250;
            random_report(rb);
            send_report(rb, 1'b0);
            reports++;
        end
    endtask

    // output side stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (squeeze_len > 0)
            begin
                hold_left   = squeeze_len;
                squeeze_len = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (out_gaps && $urandom_range(0, 6) == 0)
            begin
                m_tready  <= 1'b0;
                hold_left = $urandom_range(0, 10);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tab_ev_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (events_due.size() == 0)
                flag_mismatch("word with nothing expected", m_tdata, 0);
            else
            begin
                want = events_due.pop_front();
                if (m_tdata[0] !== want.dev)
                    flag_mismatch("target_device", m_tdata[0], want.dev);
                if (m_tdata[2:1] !== want.etype)
                    flag_mismatch("event_type", m_tdata[2:1], want.etype);
                if (m_tdata[7:3] !== want.code)
                    flag_mismatch("event_code", m_tdata[7:3], want.code);
                if (m_tdata[40:8] !== want.value)
                    flag_mismatch("event_value", m_tdata[40:8], want.value);
                if (m_tlast !== want.last)
                    flag_mismatch("last_event", m_tlast, want.last);
            end
        end
    end

    initial
    begin
        logic [7:0] rb [$];
        // len, id, kind, b5, fill, tiltx, tilty, silent
        dir_rows = '{
            '{5'd12, 8'h08, 8'h87, 8'hff, 8'hff, 8'h80, 8'h80, 1'b0},
            '{5'd12, 8'h08, 8'h00, 8'h55, 8'haa, 8'h01, 8'hff, 1'b0},
            '{5'd12, 8'h08, 8'he0, 8'hff, 8'hff, 8'h00, 8'h00, 1'b0},
            '{5'd12, 8'h08, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0},
            '{5'd12, 8'h08, 8'hf0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0},
            '{5'd11, 8'h08, 8'h87, 8'h12, 8'h34, 8'h00, 8'h00, 1'b1},
            '{5'd12, 8'h09, 8'h87, 8'h12, 8'h34, 8'h10, 8'h20, 1'b1},
            '{5'd12, 8'h08, 8'he1, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1},
            '{5'd1,  8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1},
            '{5'd16, 8'h08, 8'h85, 8'h12, 8'h34, 8'h56, 8'h9a, 1'b0}
        };
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            row_bytes(dir_rows[i], rb);
            send_report(rb, dir_rows[i].silent);
        end

        set_reg(REG_REPORT_ID, 32'h0);
        set_reg(REG_PEN_SERIAL, 32'h0);
        random_phase(12, 1'b0, 1'b0);

        set_reg(REG_REPORT_ID, 32'hffff_ffff);
        set_reg(REG_PEN_SERIAL, 32'hffff_ffff);
        random_phase(24, 1'b1, 1'b0);

        set_reg(REG_REPORT_ID, $urandom);
        set_reg(REG_PEN_SERIAL, $urandom);
        random_phase(12, 1'b0, 1'b0);

        set_reg(REG_REPORT_ID, REPORT_ID_RESET);
        set_reg(REG_PEN_SERIAL, PEN_SERIAL_RESET);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        random_phase(12, 1'b0, 1'b1);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (miss_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tabev_pkg.sv
rtl/core/tabev_datapath.sv
rtl/core/tabev_ctrl.sv
rtl/core/tablet_report_to_input_events_top.sv
verif/tb_tablet_report_to_input_events_top.sv
